### rtl/core/tte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, codes and helpers of the timer table engine.
// ----------------------------------------------------------------------------
package tte_pkg;

    // command opcodes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_ADD_ACK = 2'd0;
    localparam logic [1:0] KIND_DEL_ACK = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;

    // result status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_DUP       = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    // fired results per tick
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_CNT_W  = $clog2(MAX_RESULTS + 1);

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] last_time;
        logic [30:0] period;
        logic [30:0] delay;
    } slot_entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [15:0] id;
        logic        last;
    } result_t;

    function automatic result_t mk_result(logic [1:0] kind, logic [1:0] status,
                                          logic [15:0] id, logic last);
        result_t r;
        r.kind   = kind;
        r.status = status;
        r.id     = id;
        r.last   = last;
        return r;
    endfunction

endpackage

### rtl/core/tte_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_slot_ram
// Slot memory of the timer table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tte_slot_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  tte_pkg::slot_entry_t wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output tte_pkg::slot_entry_t rdata
);

    tte_pkg::slot_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/timer_table_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_engine_top
// Table of periodic timers keyed by id, with add, delete and tick commands.
// ----------------------------------------------------------------------------
// The timers sit in one slot memory kept sorted by id, entries 0 to count-1,
// so a tick simply walks the memory in address order. A command is taken
// when start is high and busy is low; results leave one beat per cycle on
// result_valid and cannot be held off. A tick reads one memory entry a
// cycle, writes each due entry back as its read data returns and ends with
// a final beat for the last result; a tick fires at most 16 timers, lowest
// ids first. A delete searches, then shifts the tail down one entry a
// cycle; an add searches, shifts the tail up and writes the new entry.
// A delete of id 0, a tick on an empty table and an unused opcode finish
// in the accept cycle.
// ----------------------------------------------------------------------------
module timer_table_engine_top #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [15:0] timer_id,
    input  logic [30:0] first_delay,
    input  logic [30:0] period,
    input  logic [31:0] now_time,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [1:0]  status,
    output logic [15:0] fired_id,
    output logic        last_result
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int FCW   = tte_pkg::FIRE_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT_UP,
        ST_SHIFT_DOWN,
        ST_INS,
        ST_TICK,
        ST_FLUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              iss_reg, iss_next;
    logic              rd_pend_reg, rd_pend_next;
    logic [CNT_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    logic [FCW-1:0]    fire_cnt_reg, fire_cnt_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [15:0]       pend_id_reg, pend_id_next;

    logic [1:0]        cmd_op_reg, cmd_op_next;
    logic [15:0]       cmd_id_reg, cmd_id_next;
    logic [30:0]       cmd_delay_reg, cmd_delay_next;
    logic [30:0]       cmd_period_reg, cmd_period_next;
    logic [31:0]       cmd_now_reg, cmd_now_next;

    logic              result_valid_reg, result_valid_next;
    tte_pkg::result_t  result_reg, result_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    tte_pkg::slot_entry_t ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    tte_pkg::slot_entry_t entry;

    logic              accept;
    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  j_inc;
    logic [CNT_W-1:0]  rd_idx_inc;
    logic [CNT_W-1:0]  rd_idx_dec;
    logic              last_idx;
    logic              id_eq;
    logic              id_gt;
    logic [31:0]       elapsed;
    logic [30:0]       threshold;
    logic              due;

    tte_slot_ram #(
        .DEPTH  (TABLE_SLOTS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (entry)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    assign count_m1   = count_reg - CNT_W'(1);
    assign j_inc      = j_reg + CNT_W'(1);
    assign rd_idx_inc = rd_idx_reg + CNT_W'(1);
    assign rd_idx_dec = rd_idx_reg - CNT_W'(1);
    assign last_idx   = (rd_idx_reg == count_m1);
    assign id_eq      = (entry.id == cmd_id_reg);
    assign id_gt      = (entry.id > cmd_id_reg);

    // wrapping age against the first delay, or the period once that is spent
    assign elapsed   = cmd_now_reg - entry.last_time;
    assign threshold = (entry.delay == 31'd0) ? entry.period : entry.delay;
    assign due       = (elapsed >= {1'b0, threshold});

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        j_next            = j_reg;
        iss_next          = iss_reg;
        rd_pend_next      = iss_reg;
        rd_idx_next       = j_reg;
        pos_next          = pos_reg;
        fire_cnt_next     = fire_cnt_reg;
        pend_valid_next   = pend_valid_reg;
        pend_id_next      = pend_id_reg;
        cmd_op_next       = cmd_op_reg;
        cmd_id_next       = cmd_id_reg;
        cmd_delay_next    = cmd_delay_reg;
        cmd_period_next   = cmd_period_reg;
        cmd_now_next      = cmd_now_reg;
        result_valid_next = 1'b0;
        result_next       = result_reg;

        ram_we    = 1'b0;
        ram_waddr = rd_idx_reg[IDX_W-1:0];
        ram_wdata = entry;
        ram_re    = iss_reg;
        ram_raddr = j_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_op_next     = opcode;
                    cmd_id_next     = timer_id;
                    cmd_delay_next  = first_delay;
                    cmd_period_next = period;
                    cmd_now_next    = now_time;
                    unique case (opcode)
                        tte_pkg::OP_ADD:
                        begin
                            if (count_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = ST_INS;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = '0;
                                rd_pend_next = 1'b1;
                                rd_idx_next  = '0;
                                j_next       = CNT_W'(1);
                                iss_next     = (count_reg > CNT_W'(1));
                                state_next   = ST_SCAN;
                            end
                        end
                        tte_pkg::OP_DEL:
                        begin
                            if (timer_id == 16'd0 || count_reg == '0)
                            begin
                                result_valid_next = 1'b1;
                                result_next = tte_pkg::mk_result(tte_pkg::KIND_DEL_ACK,
                                    tte_pkg::STAT_NOT_FOUND, timer_id, 1'b1);
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = '0;
                                rd_pend_next = 1'b1;
                                rd_idx_next  = '0;
                                j_next       = CNT_W'(1);
                                iss_next     = (count_reg > CNT_W'(1));
                                state_next   = ST_SCAN;
                            end
                        end
                        tte_pkg::OP_TICK:
                        begin
                            if (count_reg != '0)
                            begin
                                ram_re          = 1'b1;
                                ram_raddr       = '0;
                                rd_pend_next    = 1'b1;
                                rd_idx_next     = '0;
                                j_next          = CNT_W'(1);
                                iss_next        = (count_reg > CNT_W'(1));
                                fire_cnt_next   = '0;
                                pend_valid_next = 1'b0;
                                state_next      = ST_TICK;
                            end
                        end
                        tte_pkg::OP_NONE:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (iss_reg)
                begin
                    j_next   = j_inc;
                    iss_next = (j_inc < count_reg);
                end
                if (rd_pend_reg)
                begin
                    if (cmd_op_reg == tte_pkg::OP_ADD)
                    begin
                        if (id_eq)
                        begin
                            result_valid_next = 1'b1;
                            result_next = tte_pkg::mk_result(tte_pkg::KIND_ADD_ACK,
                                tte_pkg::STAT_DUP, cmd_id_reg, 1'b1);
                            iss_next     = 1'b0;
                            rd_pend_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                        else if (id_gt || last_idx)
                        begin
                            iss_next     = 1'b0;
                            rd_pend_next = 1'b0;
                            if (count_reg == CNT_W'(TABLE_SLOTS))
                            begin
                                result_valid_next = 1'b1;
                                result_next = tte_pkg::mk_result(tte_pkg::KIND_ADD_ACK,
                                    tte_pkg::STAT_FULL, cmd_id_reg, 1'b1);
                                state_next = ST_IDLE;
                            end
                            else if (id_gt)
                            begin
                                // open a gap at this entry by moving the tail up
                                pos_next   = rd_idx_reg;
                                j_next     = count_m1;
                                iss_next   = 1'b1;
                                state_next = ST_SHIFT_UP;
                            end
                            else
                            begin
                                pos_next   = count_reg;
                                state_next = ST_INS;
                            end
                        end
                    end
                    else
                    begin
                        if (id_eq)
                        begin
                            rd_pend_next = 1'b0;
                            if (last_idx)
                            begin
                                count_next        = count_m1;
                                result_valid_next = 1'b1;
                                result_next = tte_pkg::mk_result(tte_pkg::KIND_DEL_ACK,
                                    tte_pkg::STAT_OK, cmd_id_reg, 1'b1);
                                iss_next   = 1'b0;
                                state_next = ST_IDLE;
                            end
                            else
                            begin
                                pos_next   = rd_idx_reg;
                                j_next     = rd_idx_inc;
                                iss_next   = 1'b1;
                                state_next = ST_SHIFT_DOWN;
                            end
                        end
                        else if (id_gt || last_idx)
                        begin
                            result_valid_next = 1'b1;
                            result_next = tte_pkg::mk_result(tte_pkg::KIND_DEL_ACK,
                                tte_pkg::STAT_NOT_FOUND, cmd_id_reg, 1'b1);
                            iss_next     = 1'b0;
                            rd_pend_next = 1'b0;
                            state_next   = ST_IDLE;
                        end
                    end
                end
            end

            ST_SHIFT_UP:
            begin
                if (iss_reg)
                begin
                    j_next   = j_reg - CNT_W'(1);
                    iss_next = (j_reg != pos_reg);
                end
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_inc[IDX_W-1:0];
                    ram_wdata = entry;
                    if (rd_idx_reg == pos_reg)
                    begin
                        iss_next     = 1'b0;
                        rd_pend_next = 1'b0;
                        state_next   = ST_INS;
                    end
                end
            end

            ST_INS:
            begin
                ram_we              = 1'b1;
                ram_waddr           = pos_reg[IDX_W-1:0];
                ram_wdata.id        = cmd_id_reg;
                ram_wdata.last_time = cmd_now_reg;
                ram_wdata.period    = cmd_period_reg;
                ram_wdata.delay     = cmd_delay_reg;
                count_next          = count_reg + CNT_W'(1);
                result_valid_next   = 1'b1;
                result_next = tte_pkg::mk_result(tte_pkg::KIND_ADD_ACK,
                    tte_pkg::STAT_OK, cmd_id_reg, 1'b1);
                iss_next     = 1'b0;
                rd_pend_next = 1'b0;
                state_next   = ST_IDLE;
            end

            ST_SHIFT_DOWN:
            begin
                if (iss_reg)
                begin
                    j_next   = j_inc;
                    iss_next = (j_inc < count_reg);
                end
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = rd_idx_dec[IDX_W-1:0];
                    ram_wdata = entry;
                    if (last_idx)
                    begin
                        count_next        = count_m1;
                        result_valid_next = 1'b1;
                        result_next = tte_pkg::mk_result(tte_pkg::KIND_DEL_ACK,
                            tte_pkg::STAT_OK, cmd_id_reg, 1'b1);
                        iss_next     = 1'b0;
                        rd_pend_next = 1'b0;
                        state_next   = ST_IDLE;
                    end
                end
            end

            ST_TICK:
            begin
                if (iss_reg)
                begin
                    j_next   = j_inc;
                    iss_next = (j_inc < count_reg);
                end
                if (rd_pend_reg)
                begin
                    if (due)
                    begin
                        ram_we              = 1'b1;
                        ram_waddr           = rd_idx_reg[IDX_W-1:0];
                        ram_wdata.last_time = cmd_now_reg;
                        ram_wdata.delay     = 31'd0;
                        // each fire is held back until the next one or the flush so the final one can be flagged
                        if (pend_valid_reg)
                        begin
                            result_valid_next = 1'b1;
                            result_next = tte_pkg::mk_result(tte_pkg::KIND_FIRED,
                                tte_pkg::STAT_OK, pend_id_reg, 1'b0);
                        end
                        pend_valid_next = 1'b1;
                        pend_id_next    = entry.id;
                        fire_cnt_next   = fire_cnt_reg + FCW'(1);
                    end
                    if ((due && fire_cnt_reg == FCW'(tte_pkg::MAX_RESULTS - 1)) || last_idx)
                    begin
                        iss_next     = 1'b0;
                        rd_pend_next = 1'b0;
                        state_next   = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    result_valid_next = 1'b1;
                    result_next = tte_pkg::mk_result(tte_pkg::KIND_FIRED,
                        tte_pkg::STAT_OK, pend_id_reg, 1'b1);
                end
                pend_valid_next = 1'b0;
                iss_next        = 1'b0;
                rd_pend_next    = 1'b0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                iss_next     = 1'b0;
                rd_pend_next = 1'b0;
                state_next   = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            iss_reg          <= 1'b0;
            rd_pend_reg      <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            iss_reg          <= iss_next;
            rd_pend_reg      <= rd_pend_next;
            pend_valid_reg   <= pend_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg          <= j_next;
        rd_idx_reg     <= rd_idx_next;
        pos_reg        <= pos_next;
        fire_cnt_reg   <= fire_cnt_next;
        pend_id_reg    <= pend_id_next;
        cmd_op_reg     <= cmd_op_next;
        cmd_id_reg     <= cmd_id_next;
        cmd_delay_reg  <= cmd_delay_next;
        cmd_period_reg <= cmd_period_next;
        cmd_now_reg    <= cmd_now_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result_kind  = result_reg.kind;
    assign status       = result_reg.status;
    assign fired_id     = result_reg.id;
    assign last_result  = result_reg.last;

    // table fill never exceeds the slot count
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_SLOTS))
        else $error("slot count above table size");

    // fill moves by at most one entry per command
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            (count_reg == $past(count_reg) + CNT_W'(1) ||
             count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("slot count jumped");

    // a non-final beat only comes while the engine is still walking a tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_result) |-> (busy && result_kind == tte_pkg::KIND_FIRED))
        else $error("intermediate result outside a tick");

    // a held fire never survives into idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("fired result lost at end of tick");

    // the write-back never lands on the entry being read in the same cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("slot memory read and write collide");

endmodule

### bench/timer_table_engine_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_table_engine_top_tb
// Self-checking bench for the timer table engine. Add, delete and tick
// commands go in through the start/busy handshake. A behavioral table model
// predicts every acknowledge and fired beat, and each beat that comes out is
// checked in order. Directed tests cover the acknowledge codes, the firing
// rules and a full table. A long random run follows, drawing ids from a small
// pool so that duplicates, deletes of present timers and a full table recur.
// ----------------------------------------------------------------------------
module timer_table_engine_top_tb;

    localparam int SLOTS          = 16;
    localparam int RANDOM_ITEMS   = 100;
    localparam int END_PAUSE      = 60;
    // slowest command is an add that shifts the whole table
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PRINT_LIMIT    = 60;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [15:0] timer_id;
    logic [30:0] first_delay;
    logic [30:0] period;
    logic [31:0] now_time;
    logic        result_valid;
    logic [1:0]  result_kind;
    logic [1:0]  status;
    logic [15:0] fired_id;
    logic        last_result;

    // behavioral copy of the timer table
    logic        tbl_valid  [SLOTS];
    logic [15:0] tbl_id     [SLOTS];
    logic [31:0] tbl_last   [SLOTS];
    logic [30:0] tbl_period [SLOTS];
    logic [30:0] tbl_delay  [SLOTS];

    tte_pkg::result_t pending_beats [$];
    int unsigned      mismatch_count;
    int unsigned      quiet_cycles;
    bit               idle_on;
    logic [31:0]      cur_time;

    timer_table_engine_top #(
        .TABLE_SLOTS (SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .timer_id     (timer_id),
        .first_delay  (first_delay),
        .period       (period),
        .now_time     (now_time),
        .result_valid (result_valid),
        .result_kind  (result_kind),
        .status       (status),
        .fired_id     (fired_id),
        .last_result  (last_result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------
    function automatic int find_timer(logic [15:0] id);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (tbl_valid[i] && tbl_id[i] == id)
                return i;
        end
        return -1;
    endfunction

    function automatic void apply_timer_cmd(logic [1:0] op, logic [15:0] id,
                                            logic [30:0] dly, logic [30:0] per,
                                            logic [31:0] now);
        int          hit;
        int          free_slot;
        int          best;
        bit          done [SLOTS];
        logic [31:0] elapsed;
        logic [31:0] due_at;
        logic [15:0] fire_ids [$];

        case (op)
            tte_pkg::OP_ADD:
            begin
                hit = find_timer(id);
                free_slot = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                begin
                    if (!tbl_valid[i])
                        free_slot = i;
                end
                if (hit >= 0)
                    pending_beats.push_back(tte_pkg::mk_result(tte_pkg::KIND_ADD_ACK,
                        tte_pkg::STAT_DUP, id, 1'b1));
                else if (free_slot < 0)
                    pending_beats.push_back(tte_pkg::mk_result(tte_pkg::KIND_ADD_ACK,
                        tte_pkg::STAT_FULL, id, 1'b1));
                else
                begin
                    tbl_valid[free_slot]  = 1'b1;
                    tbl_id[free_slot]     = id;
                    tbl_last[free_slot]   = now;
                    tbl_period[free_slot] = per;
                    tbl_delay[free_slot]  = dly;
                    pending_beats.push_back(tte_pkg::mk_result(tte_pkg::KIND_ADD_ACK,
                        tte_pkg::STAT_OK, id, 1'b1));
                end
            end
            tte_pkg::OP_DEL:
            begin
                // id 0 can never be deleted, even when present
                hit = (id != 16'd0) ? find_timer(id) : -1;
                if (hit < 0)
                    pending_beats.push_back(tte_pkg::mk_result(tte_pkg::KIND_DEL_ACK,
                        tte_pkg::STAT_NOT_FOUND, id, 1'b1));
                else
                begin
                    tbl_valid[hit] = 1'b0;
                    pending_beats.push_back(tte_pkg::mk_result(tte_pkg::KIND_DEL_ACK,
                        tte_pkg::STAT_OK, id, 1'b1));
                end
            end
            tte_pkg::OP_TICK:
            begin
                for (int i = 0; i < SLOTS; i++)
                    done[i] = 1'b0;
                // visit timers in ascending id order
                while (1)
                begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (tbl_valid[i] && !done[i] &&
                            (best < 0 || tbl_id[i] < tbl_id[best]))
                            best = i;
                    end
                    if (best < 0 || fire_ids.size() >= tte_pkg::MAX_RESULTS)
                        break;
                    done[best] = 1'b1;
                    elapsed = now - tbl_last[best];
                    due_at  = (tbl_delay[best] == 31'd0) ? {1'b0, tbl_period[best]}
                                                         : {1'b0, tbl_delay[best]};
                    if (elapsed >= due_at)
                    begin
                        tbl_delay[best] = 31'd0;
                        tbl_last[best]  = now;
                        fire_ids.push_back(tbl_id[best]);
                    end
                end
                for (int k = 0; k < fire_ids.size(); k++)
                    pending_beats.push_back(tte_pkg::mk_result(tte_pkg::KIND_FIRED,
                        tte_pkg::STAT_OK, fire_ids[k], (k == fire_ids.size() - 1)));
            end
            default:
            begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // command driver
    // ------------------------------------------------------------------------
    task automatic issue_cmd(logic [1:0] op, logic [15:0] id, logic [30:0] dly,
                             logic [30:0] per, logic [31:0] now);
        if (idle_on && $urandom_range(0, 99) < 26)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start       <= 1'b1;
        opcode      <= op;
        timer_id    <= id;
        first_delay <= dly;
        period      <= per;
        now_time    <= now;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        apply_timer_cmd(op, id, dly, per, now);
    endtask

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    always @(posedge clk)
    begin : beat_check
        tte_pkg::result_t want;
        if (rst_n && result_valid === 1'b1)
        begin
            if (pending_beats.size() == 0)
                flag_mismatch("result beat with none pending", {29'd0, result_kind,
                              last_result}, 32'd0);
            else
            begin
                want = pending_beats.pop_front();
                if (result_kind !== want.kind)
                    flag_mismatch("result_kind", 32'(result_kind), 32'(want.kind));
                if (status !== want.status)
                    flag_mismatch("status", 32'(status), 32'(want.status));
                if (fired_id !== want.id)
                    flag_mismatch("fired_id", 32'(fired_id), 32'(want.id));
                if (last_result !== want.last)
                    flag_mismatch("last_result", 32'(last_result), 32'(want.last));
            end
        end
    end

    // nothing accepted on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid === 1'b1)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_acks();
        issue_cmd(tte_pkg::OP_ADD, 16'h0000, 31'd0, 31'h7FFF_FFFF, 32'h0000_0000);
        issue_cmd(tte_pkg::OP_ADD, 16'h0000, 31'd5, 31'd5, 32'h0000_0010);
        issue_cmd(tte_pkg::OP_ADD, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue_cmd(tte_pkg::OP_DEL, 16'h0000, 31'd0, 31'd0, 32'd0);
        issue_cmd(tte_pkg::OP_DEL, 16'h1234, 31'd0, 31'd0, 32'd0);
        issue_cmd(tte_pkg::OP_DEL, 16'hFFFF, 31'd0, 31'd0, 32'd0);
        issue_cmd(tte_pkg::OP_NONE, 16'hFFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_firing();
        // id 0 waits out its maximum period
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'd5);
        // zero period fires on every tick
        issue_cmd(tte_pkg::OP_ADD, 16'd7, 31'd0, 31'd0, 32'd100);
        // first delay across the time wrap
        issue_cmd(tte_pkg::OP_ADD, 16'd3, 31'd10, 31'd50, 32'hFFFF_FFF8);
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'd1);
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'd2);
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'd51);
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'd52);
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'h8000_0004);
    endtask

    task automatic test_full_table();
        // the last add finds the table full
        for (int k = 0; k < SLOTS - 2; k++)
            issue_cmd(tte_pkg::OP_ADD, 16'd100 + k[15:0], 31'd0, 31'd0, 32'h8000_0010);
        // every timer is due: a tick with the most fired beats
        issue_cmd(tte_pkg::OP_TICK, 16'd0, 31'd0, 31'd0, 32'h0000_0003);
    endtask

    function automatic logic [15:0] pick_id();
        return ($urandom_range(0, 99) < 90) ? 16'($urandom_range(0, 23))
                                            : 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [30:0] pick_span(int zero_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < zero_pct)
            return 31'd0;
        else if (roll < 85)
            return 31'($urandom_range(1, 80));
        else
            return 31'($urandom);
    endfunction

    task automatic test_random_traffic();
        int          issued;
        int          roll;
        logic [31:0] stamp;
        issued   = 0;
        cur_time = 32'h0000_0010;
        while (issued < RANDOM_ITEMS)
        begin
            // a long run of back-to-back commands in the middle
            idle_on = (issued < 30 || issued >= 70);
            if ($urandom_range(0, 99) < 10)
                cur_time = $urandom;
            else
                cur_time = cur_time + $urandom_range(0, 60);
            stamp = ($urandom_range(0, 99) < 90) ? cur_time : $urandom;
            roll  = $urandom_range(0, 99);
            if (roll < 35)
                issue_cmd(tte_pkg::OP_ADD, pick_id(), pick_span(50), pick_span(15), stamp);
            else if (roll < 60)
                issue_cmd(tte_pkg::OP_DEL, pick_id(), pick_span(50), pick_span(50), stamp);
            else if (roll < 95)
                issue_cmd(tte_pkg::OP_TICK, pick_id(), pick_span(50), pick_span(50),
                          cur_time);
            else
                issue_cmd(tte_pkg::OP_NONE, pick_id(), pick_span(50), pick_span(50), stamp);
            if (roll < 95)
                issued++;
        end
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        start          <= 1'b0;
        opcode         <= tte_pkg::OP_NONE;
        timer_id       <= 16'd0;
        first_delay    <= 31'd0;
        period         <= 31'd0;
        now_time       <= 32'd0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        for (int i = 0; i < SLOTS; i++)
            tbl_valid[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_acks();
        test_firing();
        test_full_table();
        test_random_traffic();

        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (END_PAUSE) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
